>>> hw/rtl/mcbb_pkg.sv
// Shared constants and types for the masked colormap block blitter.
`default_nettype none
package mcbb_pkg;

   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 200;

   localparam int POS_W    = 12;
   localparam int SIZE_W   = 12;
   localparam int DPITCH_W = 13;
   localparam int CNT_W    = 11;
   localparam int COUNT_MAX = 2048;
   localparam int PIX_W    = 8;
   localparam int MAP_DEPTH = 256;
   localparam int MAP_AW   = $clog2(MAP_DEPTH);
   localparam int OFF_W    = 20;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 13;

   localparam int SX_W = $clog2(SCREEN_WIDTH);
   localparam int SY_W = $clog2(SCREEN_HEIGHT);

   // request actions
   localparam logic ACT_MAP_LOAD = 1'b0;
   localparam logic ACT_PIXEL    = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] REG_POS_X        = 3'd0;
   localparam logic [CSR_AW-1:0] REG_POS_Y        = 3'd1;
   localparam logic [CSR_AW-1:0] REG_BLOCK_WIDTH  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_BLOCK_HEIGHT = 3'd3;
   localparam logic [CSR_AW-1:0] REG_SOURCE_PITCH = 3'd4;
   localparam logic [CSR_AW-1:0] REG_DEST_PITCH   = 3'd5;

   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [SIZE_W-1:0] block_width;
      logic [SIZE_W-1:0] block_height;
      logic [SIZE_W-1:0] source_pitch;
   } scan_cfg_type;

   typedef struct packed {
      logic            visible;   // inside block and on screen
      logic [SX_W-1:0] sx;
      logic [SY_W-1:0] sy;
   } scan_pos_type;

endpackage
`default_nettype wire

>>> hw/rtl/mcbb_scan.sv
// Source column/row counters and screen clipping for the blitter.
`default_nettype none
module mcbb_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire mcbb_pkg::scan_cfg_type cfg,
   output mcbb_pkg::scan_pos_type     pos
);
   import mcbb_pkg::*;

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [SIZE_W-1:0] pitch_eff, height_eff;
   logic [SIZE_W-1:0] col_inc, row_inc;
   logic signed [POS_W:0] sx, sy;
   logic sx_ok, sy_ok, in_block;

   // zero acts as one, anything above the counter range saturates
   always_comb begin
      if (cfg.source_pitch == '0)
         pitch_eff = SIZE_W'(1);
      else if (cfg.source_pitch > SIZE_W'(COUNT_MAX))
         pitch_eff = SIZE_W'(COUNT_MAX);
      else
         pitch_eff = cfg.source_pitch;
      if (cfg.block_height == '0)
         height_eff = SIZE_W'(1);
      else if (cfg.block_height > SIZE_W'(COUNT_MAX))
         height_eff = SIZE_W'(COUNT_MAX);
      else
         height_eff = cfg.block_height;
   end

   assign col_inc = {1'b0, col_ff} + SIZE_W'(1);
   assign row_inc = {1'b0, row_ff} + SIZE_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (col_inc >= pitch_eff) begin
            col_in = '0;
            row_in = (row_inc >= height_eff) ? '0 : row_inc[CNT_W-1:0];
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign sx = $signed({cfg.pos_x[POS_W-1], cfg.pos_x}) + $signed({2'b00, col_ff});
   assign sy = $signed({cfg.pos_y[POS_W-1], cfg.pos_y}) + $signed({2'b00, row_ff});

   assign sx_ok = !sx[POS_W] && (sx < (POS_W+1)'(SCREEN_WIDTH));
   assign sy_ok = !sy[POS_W] && (sy < (POS_W+1)'(SCREEN_HEIGHT));
   assign in_block = ({1'b0, col_ff} < cfg.block_width) &&
                     ({1'b0, row_ff} < cfg.block_height);

   assign pos.visible = in_block && sx_ok && sy_ok;
   assign pos.sx      = sx[SX_W-1:0];
   assign pos.sy      = sy[SY_W-1:0];

endmodule
`default_nettype wire

>>> hw/rtl/masked_colormap_block_blit_top.sv
// Top level of the masked colormap block blitter.
// Pipeline: two register stages, s1 then the response register; a drawn pixel's
//   write is offered once s1 advances into the response register.
// Throughput: one request per cycle unless s1 is full and the response stalls;
//   the colormap RAM takes one read per pixel or one write per load, never both.
// Reset: synchronous; clears counters, registers to defaults and pipeline valids.
// The colormap RAM is not cleared and holds garbage until loaded.
`default_nettype none
module masked_colormap_block_blit_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [mcbb_pkg::CSR_AW-1:0]   csr_index,
   input  wire logic [mcbb_pkg::CSR_DW-1:0]   csr_wdata,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_action,
   input  wire logic [7:0]                    req_map_index,
   input  wire logic [7:0]                    req_map_value,
   input  wire logic [7:0]                    req_pixel,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [mcbb_pkg::OFF_W-1:0]    rsp_dest_offset,
   output      logic [7:0]                    rsp_color
);
   import mcbb_pkg::*;

   scan_cfg_type          cfg_ff;
   logic [DPITCH_W-1:0]   dest_pitch_ff;
   scan_pos_type          pos;

   logic [PIX_W-1:0]      color_map_mem [MAP_DEPTH];

   logic                  accept, pix_accept, load_accept;
   logic                  s1_valid_ff, s1_valid_in, s1_adv;
   logic [SX_W-1:0]       s1_sx_ff;
   logic [SY_W-1:0]       s1_sy_ff;
   logic [PIX_W-1:0]      s1_color_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]      rsp_off_ff;
   logic [PIX_W-1:0]      rsp_color_ff;
   logic [31:0]           prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x        <= '0;
         cfg_ff.pos_y        <= '0;
         cfg_ff.block_width  <= '0;
         cfg_ff.block_height <= '0;
         cfg_ff.source_pitch <= SIZE_W'(1);
         dest_pitch_ff       <= DPITCH_W'(320);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_POS_X:        cfg_ff.pos_x        <= csr_wdata[POS_W-1:0];
            REG_POS_Y:        cfg_ff.pos_y        <= csr_wdata[POS_W-1:0];
            REG_BLOCK_WIDTH:  cfg_ff.block_width  <= csr_wdata[SIZE_W-1:0];
            REG_BLOCK_HEIGHT: cfg_ff.block_height <= csr_wdata[SIZE_W-1:0];
            REG_SOURCE_PITCH: cfg_ff.source_pitch <= csr_wdata[SIZE_W-1:0];
            REG_DEST_PITCH:   dest_pitch_ff       <= csr_wdata[DPITCH_W-1:0];
            default: ;
         endcase
      end
   end

   mcbb_scan u_scan (
      .clock (clock),
      .reset (reset),
      .step  (pix_accept),
      .cfg   (cfg_ff),
      .pos   (pos)
   );

   assign s1_adv      = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign accept      = req_valid && req_ready;
   assign pix_accept  = accept && (req_action == ACT_PIXEL);
   assign load_accept = accept && (req_action == ACT_MAP_LOAD);

   // colormap RAM: one write per load, registered read per pixel
   always_ff @(posedge clock) begin
      if (load_accept)
         color_map_mem[req_map_index] <= req_map_value;
      if (pix_accept)
         s1_color_ff <= color_map_mem[req_pixel];
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept)
         s1_valid_in = pix_accept && pos.visible && (req_pixel != '0);
      else if (s1_adv)
         s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_sx_ff <= pos.sx;
         s1_sy_ff <= pos.sy;
      end
   end

   assign prod = 32'(s1_sy_ff) * 32'(dest_pitch_ff);

   assign rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_off_ff   <= OFF_W'(prod + 32'(s1_sx_ff));
         rsp_color_ff <= s1_color_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dest_offset = rsp_off_ff;
   assign rsp_color       = rsp_color_ff;

`ifndef SYNTHESIS
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline is full");

   a_load_no_write: assert property (@(posedge clock) disable iff (reset)
      load_accept |=> !s1_valid_ff)
      else $error("colormap load produced a pixel in flight");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response raised without a staged pixel");
`endif

endmodule
`default_nettype wire

>>> test/tb_masked_colormap_block_blit_top.sv
// Self-checking testbench for the masked colormap block blitter top level.
`timescale 1ns / 1ps

module tb_masked_colormap_block_blit_top;
   import mcbb_pkg::*;

   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 200;
   localparam int DRAIN_CYCLES   = 4;

   typedef struct packed {
      logic       action;
      logic [7:0] map_index;
      logic [7:0] map_value;
      logic [7:0] pixel;
   } blit_req_type;

   typedef struct packed {
      logic [OFF_W-1:0] dest_offset;
      logic [7:0]       color;
   } pixel_write_type;

   typedef enum {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_OFF} idle_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_index = '0;
   logic [CSR_DW-1:0]   csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_action = ACT_MAP_LOAD;
   logic [7:0]          req_map_index = '0;
   logic [7:0]          req_map_value = '0;
   logic [7:0]          req_pixel = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [OFF_W-1:0]    rsp_dest_offset;
   logic [7:0]          rsp_color;

   // predicted block state
   logic [POS_W-1:0]    cfg_pos_x = '0;
   logic [POS_W-1:0]    cfg_pos_y = '0;
   logic [SIZE_W-1:0]   cfg_width = '0;
   logic [SIZE_W-1:0]   cfg_height = '0;
   logic [SIZE_W-1:0]   cfg_pitch = SIZE_W'(1);
   logic [DPITCH_W-1:0] cfg_dpitch = DPITCH_W'(SCREEN_WIDTH);
   logic [CNT_W-1:0]    src_col = '0;
   logic [CNT_W-1:0]    src_row = '0;
   logic [7:0]          color_map [MAP_DEPTH];

   blit_req_type        blit_requests [$];
   pixel_write_type     writes_due [$];
   blit_req_type        offered_req;
   blit_req_type        issue_req;
   pixel_write_type     due_write;
   bit                  map_loaded [MAP_DEPTH];
   int                  requests_queued = 0;
   int                  requests_taken = 0;
   int                  stim_count = 0;
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   int                  hold_left = 0;
   bit                  hold_armed = 1'b0;
   bit                  hold_done = 1'b0;
   idle_mode_type       idle_mode = IDLE_SEND_LIGHT;

   masked_colormap_block_blit_top DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_map_index   (req_map_index),
      .req_map_value   (req_map_value),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_offset (rsp_dest_offset),
      .rsp_color       (rsp_color)
   );

   always #1 clock = ~clock;

   function automatic bit sender_pause();
      case (idle_mode)
         IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 11;
         IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 51;
         default:         return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_pause();
      case (idle_mode)
         IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 51;
         IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 11;
         default:         return 1'b0;
      endcase
   endfunction

   // Works out the write (if any) caused by one accepted request and
   // advances the source counters.
   function automatic void predict_blit(input blit_req_type rq);
      int sx, sy, pitch_n, rows_n;
      pixel_write_type wr;
      if (rq.action == ACT_MAP_LOAD) begin
         color_map[rq.map_index] = rq.map_value;
      end else begin
         sx = int'($signed(cfg_pos_x)) + int'(src_col);
         sy = int'($signed(cfg_pos_y)) + int'(src_row);
         if (int'(src_col) < int'(cfg_width) && int'(src_row) < int'(cfg_height) &&
             rq.pixel != 8'd0 && sx >= 0 && sx < SCREEN_WIDTH &&
             sy >= 0 && sy < SCREEN_HEIGHT) begin
            wr.dest_offset = OFF_W'(sy * int'(cfg_dpitch) + sx);
            wr.color = color_map[rq.pixel];
            writes_due.push_back(wr);
         end
         // zero counts act as one, oversize counts saturate at the counter range
         pitch_n = (cfg_pitch == '0) ? 1 :
                   ((int'(cfg_pitch) > COUNT_MAX) ? COUNT_MAX : int'(cfg_pitch));
         rows_n = (cfg_height == '0) ? 1 :
                  ((int'(cfg_height) > COUNT_MAX) ? COUNT_MAX : int'(cfg_height));
         if (int'(src_col) + 1 >= pitch_n) begin
            src_col = '0;
            if (int'(src_row) + 1 >= rows_n)
               src_row = '0;
            else
               src_row = src_row + 1'b1;
         end else begin
            src_col = src_col + 1'b1;
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_blit(offered_req);
            requests_taken++;
         end
         if (!req_valid || req_ready) begin
            if (blit_requests.size() != 0 && !sender_pause()) begin
               issue_req = blit_requests.pop_front();
               offered_req = issue_req;
               req_valid <= 1'b1;
               req_action <= issue_req.action;
               req_map_index <= issue_req.map_index;
               req_map_value <= issue_req.map_value;
               req_pixel <= issue_req.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (writes_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected write: dest_offset %h color %h",
                           rsp_dest_offset, rsp_color);
            end else begin
               due_write = writes_due.pop_front();
               if (due_write.dest_offset !== rsp_dest_offset ||
                   due_write.color !== rsp_color) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("write mismatch: dest_offset exp %h got %h, color exp %h got %h",
                              due_write.dest_offset, rsp_dest_offset,
                              due_write.color, rsp_color);
               end
            end
         end
         // one long hold-off so the pipeline backs up into the request side
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !receiver_pause();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic push_load(input logic [7:0] idx, input logic [7:0] value);
      blit_req_type rq;
      rq.action = ACT_MAP_LOAD;
      rq.map_index = idx;
      rq.map_value = value;
      rq.pixel = 8'($urandom);
      map_loaded[idx] = 1'b1;
      blit_requests.push_back(rq);
      requests_queued++;
      stim_count++;
   endtask

   // a nonzero pixel always has its colormap entry loaded ahead of it
   task automatic push_pixel(input logic [7:0] value);
      blit_req_type rq;
      if (value != 8'd0 && !map_loaded[value])
         push_load(value, 8'($urandom));
      rq.action = ACT_PIXEL;
      rq.map_index = 8'($urandom);
      rq.map_value = 8'($urandom);
      rq.pixel = value;
      blit_requests.push_back(rq);
      requests_queued++;
      stim_count++;
   endtask

   task automatic stream_block(input int n_pix, input int zero_pct, input int load_pct);
      for (int i = 0; i < n_pix; i++) begin
         if ($urandom_range(0, 99) < load_pct)
            push_load(8'($urandom), 8'($urandom));
         if ($urandom_range(0, 99) < zero_pct)
            push_pixel(8'd0);
         else
            push_pixel(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic wait_idle();
      while (requests_taken != requests_queued || writes_due.size() != 0)
         @(posedge clock);
      // loads and dropped pixels leave no write behind, so let the pipeline empty
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input int value);
      logic [CSR_DW-1:0] data;
      data = CSR_DW'(value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_POS_X:        cfg_pos_x = data[POS_W-1:0];
         REG_POS_Y:        cfg_pos_y = data[POS_W-1:0];
         REG_BLOCK_WIDTH:  cfg_width = data[SIZE_W-1:0];
         REG_BLOCK_HEIGHT: cfg_height = data[SIZE_W-1:0];
         REG_SOURCE_PITCH: cfg_pitch = data[SIZE_W-1:0];
         REG_DEST_PITCH:   cfg_dpitch = data[DPITCH_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input int px, input int py, input int w, input int h,
                            input int pitch, input int dpitch);
      wait_idle();
      write_reg(REG_POS_X, px);
      write_reg(REG_POS_Y, py);
      write_reg(REG_BLOCK_WIDTH, w);
      write_reg(REG_BLOCK_HEIGHT, h);
      write_reg(REG_SOURCE_PITCH, pitch);
      write_reg(REG_DEST_PITCH, dpitch);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int w, h, pitch, px, py, dpitch, rows;
      logic [7:0] clip_pix [12];
      logic [7:0] corner_pix [8];
      clip_pix = '{8'd1, 8'd255, 8'd1, 8'd0, 8'd255, 8'd1,
                   8'd255, 8'd1, 8'd255, 8'd1, 8'd1, 8'd255};
      corner_pix = '{8'd255, 8'd1, 8'd255, 8'd1, 8'd1, 8'd255, 8'd0, 8'd1};
      foreach (map_loaded[i]) map_loaded[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default registers: zero height, nothing drawn, counters stay put
      push_load(8'd255, 8'd0);
      push_load(8'd1, 8'd255);
      push_load(8'd0, 8'hAA);
      push_pixel(8'd0);
      push_pixel(8'd1);
      push_pixel(8'd255);
      // left clip, transparent zero and columns past the block width
      configure(-2, 0, 4, 2, 6, SCREEN_WIDTH);
      foreach (clip_pix[i]) push_pixel(clip_pix[i]);
      // bottom-right corner, right clip, offset wraps past 20 bits
      configure(SCREEN_WIDTH - 2, SCREEN_HEIGHT - 1, 8, 2, 8, 8191);
      foreach (corner_pix[i]) push_pixel(corner_pix[i]);

      // far off screen, oversized height and pitch
      configure(-2048, -2048, 2048, 4095, 4095, SCREEN_WIDTH);
      stream_block(20, 15, 5);
      // zero sizes and zero pitch; this also returns the counters to the origin
      configure(2047, 2047, 0, 0, 0, SCREEN_WIDTH);
      stream_block(6, 15, 0);
      configure(-4, 3, 2048, 1, 2048, SCREEN_WIDTH);
      stream_block(40, 15, 5);
      configure(2047, 2047, 0, 0, 0, SCREEN_WIDTH);
      stream_block(3, 15, 0);
      configure(0, SCREEN_HEIGHT - 10, 16, 8, 16, 8191);
      stream_block(128, 15, 5);

      stim_count = 0;
      while (stim_count < RANDOM_ITEMS) begin
         if (stim_count < RANDOM_ITEMS / 3)
            idle_mode = IDLE_SEND_LIGHT;
         else if (stim_count < 2 * RANDOM_ITEMS / 3)
            idle_mode = IDLE_SEND_HEAVY;
         else
            idle_mode = IDLE_OFF;
         w = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 12));
         pitch = w + int'($urandom_range(0, 3));
         h = $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0: px = -int'($urandom_range(0, w + 2));
            1: px = SCREEN_WIDTH - int'($urandom_range(0, w + 2));
            2: px = $urandom_range(0, SCREEN_WIDTH - 1);
            default: px = int'($urandom_range(0, 4095)) - 2048;
         endcase
         case ($urandom_range(0, 3))
            0: py = -int'($urandom_range(0, h + 2));
            1: py = SCREEN_HEIGHT - int'($urandom_range(0, h + 2));
            2: py = $urandom_range(0, SCREEN_HEIGHT - 1);
            default: py = int'($urandom_range(0, 4095)) - 2048;
         endcase
         dpitch = ($urandom_range(0, 3) == 0) ? int'($urandom_range(SCREEN_WIDTH, 8191))
                                               : SCREEN_WIDTH;
         rows = h * int'($urandom_range(1, 2));
         configure(px, py, w, h, pitch, dpitch);
         stream_block(((pitch == 0) ? 1 : pitch) * rows, 15, 8);
      end

      // receiver holds off while a fully visible block streams in
      idle_mode = IDLE_OFF;
      configure(10, 10, 16, 4, 16, SCREEN_WIDTH);
      hold_armed = 1'b1;
      stream_block(64, 0, 0);

      wait_idle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && writes_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mcbb_pkg.sv
hw/rtl/mcbb_scan.sv
hw/rtl/masked_colormap_block_blit_top.sv
test/tb_masked_colormap_block_blit_top.sv
